FILE: hdl/sobel_edge_magnitude_3x3_core_macros.svh
// Assertion macros shared by the Sobel core modules.
// Each macro expects clk and rst_n in the scope where it is used.
`ifndef SOBEL_EDGE_MAGNITUDE_3X3_CORE_MACROS_SVH
`define SOBEL_EDGE_MAGNITUDE_3X3_CORE_MACROS_SVH

// same-cycle implication
`define SEM_ASSERT_IMPL(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define SEM_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hdl/sem_pkg.sv
`timescale 1ns / 1ps

package sem_pkg;

  localparam int PIX_W      = 8;
  localparam int GRAD_W     = 11;
  localparam int MAG_W      = 11;
  localparam int IMG_W_W    = 12;
  localparam int IMG_H_W    = 16;
  localparam int CFG_DATA_W = 16;
  localparam int CFG_IDX_W  = 1;

  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 1'd1;

  localparam logic [IMG_W_W-1:0] WIDTH_RESET  = 12'd640;
  localparam logic [IMG_H_W-1:0] HEIGHT_RESET = 16'd480;

  localparam int MAX_WIDTH_DEF  = 2048;
  localparam int FIFO_DEPTH_DEF = 32;

  // square of the gradient pair fits 21 bits, so 11 root digits
  localparam int SQ_W       = 21;
  localparam int SQRT_STEPS = 11;

  localparam int IN_TDATA_W  = 8;
  localparam int OUT_TDATA_W = 40;
  localparam int OUT_PAD     = OUT_TDATA_W - 2 * GRAD_W - MAG_W;

  typedef struct packed {
    logic [PIX_W-1:0] top;
    logic [PIX_W-1:0] mid;
    logic [PIX_W-1:0] bot;
  } column_t;

  typedef struct packed {
    logic valid;
    logic emit;
    logic last;
  } lb_status_t;

  typedef struct packed {
    logic                     last;
    logic signed [GRAD_W-1:0] gx;
    logic signed [GRAD_W-1:0] gy;
    logic [SQ_W-1:0]          v;
    logic [SQ_W-1:0]          root;
  } sq_item_t;

  typedef struct packed {
    logic                     last;
    logic signed [GRAD_W-1:0] gx;
    logic signed [GRAD_W-1:0] gy;
    logic [MAG_W-1:0]         magnitude;
  } out_item_t;

endpackage

FILE: hdl/sobel_edge_magnitude_3x3_core.sv
`timescale 1ns / 1ps
// Channel   Ports                                 Contents
// in        in_tvalid/in_tready/in_tdata/in_tuser  pixel, frame_start flag
// out       out_tvalid/out_tready/out_tdata/out_tlast  magnitude, gx, gy, last
// cfg       cfg_wr_en/cfg_index/cfg_wr_data        image_width, image_height
//
// One pixel per clock while in_tready is high; an interior result reaches out_tvalid after
// the edge that accepts the pixel completing its window, through line-buffer read, window,
// gradient, square, sum, one root digit per cell of an 11-cell chain, then the queue write.
// Reset clears counters and flow control; line buffers hold no reset contents.
// in_tready drops once the 32-entry result queue plus pipeline hold that many
// transactions; a stalled sink never stops the pipeline itself.

module sobel_edge_magnitude_3x3_core #(
  parameter int MAX_WIDTH  = sem_pkg::MAX_WIDTH_DEF,
  parameter int FIFO_DEPTH = sem_pkg::FIFO_DEPTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [sem_pkg::IN_TDATA_W-1:0]   in_tdata,   // [7:0] pixel
  input  logic                             in_tuser,   // [0] frame_start
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [sem_pkg::OUT_TDATA_W-1:0]  out_tdata,  // [10:0] magnitude, [21:11] grad_x,
                                                       // [32:22] grad_y, [39:33] zero
  output logic                             out_tlast,
  input  logic                             cfg_wr_en,
  input  logic [sem_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [sem_pkg::CFG_DATA_W-1:0]   cfg_wr_data
);
  import sem_pkg::*;

  `include "sobel_edge_magnitude_3x3_core_macros.svh"

  localparam int CW = $clog2(FIFO_DEPTH + 1);

  logic       in_acc, out_acc, drop;
  column_t    col;
  lb_status_t st;
  logic       win_valid;
  sq_item_t   chain [SQRT_STEPS+1];
  logic       chain_v [SQRT_STEPS+1];
  out_item_t  fifo_wr, fifo_rd;
  logic       fifo_ne;
  logic [CW-1:0] cnt_r, cnt_nxt;

  assign in_acc  = in_tvalid && in_tready;
  assign out_acc = out_tvalid && out_tready;
  assign drop    = st.valid && !st.emit;

  sem_line_buf #(
    .MAX_WIDTH(MAX_WIDTH)
  ) u_line_buf (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_wr_data(cfg_wr_data),
    .in_acc     (in_acc),
    .pixel      (in_tdata[PIX_W-1:0]),
    .frame_start(in_tuser),
    .col_o      (col),
    .st_o       (st)
  );

  sem_window u_window (
    .clk    (clk),
    .rst_n  (rst_n),
    .col_i  (col),
    .st_i   (st),
    .valid_o(win_valid),
    .item_o (chain[0])
  );

  assign chain_v[0] = win_valid;

  for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_sqrt
    sem_sqrt_cell #(
      .STEP(k)
    ) u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .valid_i(chain_v[k]),
      .item_i (chain[k]),
      .valid_o(chain_v[k+1]),
      .item_o (chain[k+1])
    );
  end

  assign fifo_wr.last      = chain[SQRT_STEPS].last;
  assign fifo_wr.gx        = chain[SQRT_STEPS].gx;
  assign fifo_wr.gy        = chain[SQRT_STEPS].gy;
  assign fifo_wr.magnitude = chain[SQRT_STEPS].root[MAG_W-1:0];

  sem_fifo #(
    .DEPTH(FIFO_DEPTH)
  ) u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (chain_v[SQRT_STEPS]),
    .wr_data  (fifo_wr),
    .rd_en    (out_acc),
    .rd_data  (fifo_rd),
    .not_empty(fifo_ne)
  );

  // count every transaction from acceptance until it is dropped or delivered
  assign cnt_nxt = cnt_r + CW'(in_acc) - CW'(drop) - CW'(out_acc);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  assign in_tready  = (cnt_r < CW'(FIFO_DEPTH));
  assign out_tvalid = fifo_ne;
  assign out_tdata  = {{OUT_PAD{1'b0}}, fifo_rd.gy, fifo_rd.gx, fifo_rd.magnitude};
  assign out_tlast  = fifo_rd.last;

  `SEM_ASSERT_IMPL(a_cnt_bound, 1'b1, cnt_r <= CW'(FIFO_DEPTH), "credit count above queue depth")
  `SEM_ASSERT_IMPL(a_out_cnt, out_tvalid, cnt_r != '0, "result offered with no transaction counted")
  `SEM_ASSERT_NEXT(a_drop_cnt, drop && !in_acc && !out_acc, (cnt_r + CW'(1)) == $past(cnt_r),
                   "border drop did not release its credit")

endmodule

FILE: hdl/sem_line_buf.sv
`timescale 1ns / 1ps

`include "sobel_edge_magnitude_3x3_core_macros.svh"

module sem_line_buf #(
  parameter int MAX_WIDTH = sem_pkg::MAX_WIDTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_wr_en,
  input  logic [sem_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [sem_pkg::CFG_DATA_W-1:0]  cfg_wr_data,
  input  logic                            in_acc,
  input  logic [sem_pkg::PIX_W-1:0]       pixel,
  input  logic                            frame_start,
  output sem_pkg::column_t                col_o,
  output sem_pkg::lb_status_t             st_o
);
  import sem_pkg::*;

  localparam int COL_W = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int MW_W  = $clog2(MAX_WIDTH + 1);
  localparam int EW    = (MW_W > IMG_W_W) ? MW_W : IMG_W_W;

  logic [IMG_W_W-1:0] width_r;
  logic [IMG_H_W-1:0] height_r;
  logic [COL_W-1:0]   col_r, col_nxt;
  logic [IMG_H_W-1:0] row_r, row_nxt;

  logic [EW-1:0]      w_eff, c_inc;
  logic [IMG_H_W-1:0] h_eff, r0, r1, r2;
  logic [IMG_H_W:0]   r_inc;
  logic [COL_W-1:0]   c0, c1;
  logic               emit, last;

  logic               valid_a_r, emit_a_r, last_a_r, hz_r;
  logic [PIX_W-1:0]   px_a_r, byp_r, rd1_r, rd2_r;
  logic [COL_W-1:0]   col_a_r;

  logic [PIX_W-1:0]   lb_one [MAX_WIDTH];
  logic [PIX_W-1:0]   lb_two [MAX_WIDTH];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= WIDTH_RESET;
      height_r <= HEIGHT_RESET;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_IMAGE_WIDTH:  width_r  <= cfg_wr_data[IMG_W_W-1:0];
        REG_IMAGE_HEIGHT: height_r <= cfg_wr_data[IMG_H_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    w_eff = EW'(width_r);
    if (w_eff < EW'(3)) begin
      w_eff = EW'(3);
    end else if (w_eff > EW'(MAX_WIDTH)) begin
      w_eff = EW'(MAX_WIDTH);
    end
    h_eff = (height_r < IMG_H_W'(3)) ? IMG_H_W'(3) : height_r;

    c0 = frame_start ? '0 : col_r;
    r0 = frame_start ? '0 : row_r;
    // a column beyond a narrowed width starts a new row
    if (EW'(c0) >= w_eff) begin
      c1 = '0;
      r1 = r0 + IMG_H_W'(1);
    end else begin
      c1 = c0;
      r1 = r0;
    end
    r2 = (r1 >= h_eff) ? '0 : r1;

    c_inc = EW'(c1) + EW'(1);
    r_inc = {1'b0, r2} + (IMG_H_W + 1)'(1);
    if (c_inc >= w_eff) begin
      col_nxt = '0;
      row_nxt = (r_inc >= {1'b0, h_eff}) ? '0 : r_inc[IMG_H_W-1:0];
    end else begin
      col_nxt = c_inc[COL_W-1:0];
      row_nxt = r2;
    end

    emit = (r2 >= IMG_H_W'(2)) && (EW'(c1) >= EW'(2));
    last = (r2 == h_eff - IMG_H_W'(1)) && (EW'(c1) == w_eff - EW'(1));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r     <= '0;
      row_r     <= '0;
      valid_a_r <= 1'b0;
      emit_a_r  <= 1'b0;
      last_a_r  <= 1'b0;
      hz_r      <= 1'b0;
    end else begin
      valid_a_r <= in_acc;
      // row-two write of the previous transaction lands on the address read now
      hz_r      <= in_acc && valid_a_r && (col_a_r == c1);
      if (in_acc) begin
        col_r    <= col_nxt;
        row_r    <= row_nxt;
        emit_a_r <= emit;
        last_a_r <= last;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      px_a_r  <= pixel;
      col_a_r <= c1;
    end
    byp_r <= rd1_r;
  end

  // read-first: the old row-one value is the middle row
  always_ff @(posedge clk) begin
    if (in_acc) begin
      rd1_r      <= lb_one[c1];
      lb_one[c1] <= pixel;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      rd2_r <= lb_two[c1];
    end
    if (valid_a_r) begin
      lb_two[col_a_r] <= rd1_r;
    end
  end

  assign col_o.top = hz_r ? byp_r : rd2_r;
  assign col_o.mid = rd1_r;
  assign col_o.bot = px_a_r;

  assign st_o.valid = valid_a_r;
  assign st_o.emit  = emit_a_r;
  assign st_o.last  = last_a_r;

  `SEM_ASSERT_IMPL(a_hz_valid, hz_r, valid_a_r, "bypass flagged without a transaction in stage A")
  `SEM_ASSERT_IMPL(a_last_emit, valid_a_r && last_a_r, emit_a_r, "last flag on a border pixel")
  `SEM_ASSERT_IMPL(a_col_range, 1'b1, EW'(col_r) < EW'(MAX_WIDTH), "column counter out of range")

endmodule

FILE: hdl/sem_window.sv
`timescale 1ns / 1ps

module sem_window (
  input  logic                clk,
  input  logic                rst_n,
  input  sem_pkg::column_t    col_i,
  input  sem_pkg::lb_status_t st_i,
  output logic                valid_o,
  output sem_pkg::sq_item_t   item_o
);
  import sem_pkg::*;

  localparam int SUM_W = PIX_W + 2;

  // three column cells, left to right
  column_t left_r, cen_r, rgt_r;
  logic    vw_r, lw_r;

  logic signed [GRAD_W-1:0] gx_c, gy_c, gx_r, gy_r;
  logic                     vg_r, lg_r;

  logic signed [2*GRAD_W-1:0] sqx_c, sqy_c;
  logic [SQ_W-2:0]            sqx_r, sqy_r;
  logic signed [GRAD_W-1:0]   gx_s_r, gy_s_r;
  logic                       vs_r, ls_r;

  logic                     vv_r, lv_r;
  logic signed [GRAD_W-1:0] gx_v_r, gy_v_r;
  logic [SQ_W-1:0]          sum_r;

  logic [SUM_W-1:0] sum_l, sum_r_col, sum_t, sum_b;

  function automatic logic [SUM_W-1:0] wsum(input logic [PIX_W-1:0] a,
                                            input logic [PIX_W-1:0] b,
                                            input logic [PIX_W-1:0] c);
    wsum = {2'b00, a} + {1'b0, b, 1'b0} + {2'b00, c};
  endfunction

  always_ff @(posedge clk) begin
    if (st_i.valid) begin
      left_r <= cen_r;
      cen_r  <= rgt_r;
      rgt_r  <= col_i;
    end
    lw_r <= st_i.last;
  end

  always_comb begin
    sum_l     = wsum(left_r.top, left_r.mid, left_r.bot);
    sum_r_col = wsum(rgt_r.top, rgt_r.mid, rgt_r.bot);
    sum_t     = wsum(left_r.top, cen_r.top, rgt_r.top);
    sum_b     = wsum(left_r.bot, cen_r.bot, rgt_r.bot);
    gx_c      = $signed({1'b0, sum_r_col}) - $signed({1'b0, sum_l});
    gy_c      = $signed({1'b0, sum_b}) - $signed({1'b0, sum_t});
    sqx_c     = gx_r * gx_r;
    sqy_c     = gy_r * gy_r;
  end

  always_ff @(posedge clk) begin
    gx_r   <= gx_c;
    gy_r   <= gy_c;
    lg_r   <= lw_r;
    sqx_r  <= sqx_c[SQ_W-2:0];
    sqy_r  <= sqy_c[SQ_W-2:0];
    gx_s_r <= gx_r;
    gy_s_r <= gy_r;
    ls_r   <= lg_r;
    sum_r  <= {1'b0, sqx_r} + {1'b0, sqy_r};
    gx_v_r <= gx_s_r;
    gy_v_r <= gy_s_r;
    lv_r   <= ls_r;
  end

  // border positions drop out here
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vw_r <= 1'b0;
      vg_r <= 1'b0;
      vs_r <= 1'b0;
      vv_r <= 1'b0;
    end else begin
      vw_r <= st_i.valid && st_i.emit;
      vg_r <= vw_r;
      vs_r <= vg_r;
      vv_r <= vs_r;
    end
  end

  assign valid_o     = vv_r;
  assign item_o.last = lv_r;
  assign item_o.gx   = gx_v_r;
  assign item_o.gy   = gy_v_r;
  assign item_o.v    = sum_r;
  assign item_o.root = '0;

endmodule

FILE: hdl/sem_sqrt_cell.sv
`timescale 1ns / 1ps

module sem_sqrt_cell #(
  parameter int STEP = 0
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              valid_i,
  input  sem_pkg::sq_item_t item_i,
  output logic              valid_o,
  output sem_pkg::sq_item_t item_o
);
  import sem_pkg::*;

  localparam logic [SQ_W-1:0] SET_BIT = SQ_W'(1) << (2 * (SQRT_STEPS - 1 - STEP));

  logic [SQ_W:0]   trial;
  logic [SQ_W-1:0] v_nxt, root_nxt;
  logic            valid_r;
  sq_item_t        item_r;

  // one restoring digit of the integer root
  always_comb begin
    trial = {1'b0, item_i.root} + {1'b0, SET_BIT};
    if ({1'b0, item_i.v} >= trial) begin
      v_nxt    = item_i.v - trial[SQ_W-1:0];
      root_nxt = (item_i.root >> 1) + SET_BIT;
    end else begin
      v_nxt    = item_i.v;
      root_nxt = item_i.root >> 1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    item_r.last <= item_i.last;
    item_r.gx   <= item_i.gx;
    item_r.gy   <= item_i.gy;
    item_r.v    <= v_nxt;
    item_r.root <= root_nxt;
  end

  assign valid_o = valid_r;
  assign item_o  = item_r;

endmodule

FILE: hdl/sem_fifo.sv
`timescale 1ns / 1ps

module sem_fifo #(
  parameter int DEPTH = sem_pkg::FIFO_DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               wr_en,
  input  sem_pkg::out_item_t wr_data,
  input  logic               rd_en,
  output sem_pkg::out_item_t rd_data,
  output logic               not_empty
);
  import sem_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  out_item_t      mem [DEPTH];
  logic [AW-1:0]  wr_ptr_r, rd_ptr_r;
  logic [CW-1:0]  count_r;

  function automatic logic [AW-1:0] wrap_inc(input logic [AW-1:0] p);
    wrap_inc = (p == AW'(DEPTH - 1)) ? '0 : p + AW'(1);
  endfunction

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_ptr_r] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr_r <= wrap_inc(wr_ptr_r);
      end
      if (rd_en) begin
        rd_ptr_r <= wrap_inc(rd_ptr_r);
      end
      count_r <= count_r + CW'(wr_en) - CW'(rd_en);
    end
  end

  assign rd_data   = mem[rd_ptr_r];
  assign not_empty = (count_r != '0);

endmodule

FILE: tb/tb.sv
`timescale 1ns / 1ps

module tb;
  import sem_pkg::*;

  localparam int LB_DEPTH       = MAX_WIDTH_DEF;
  localparam int LB_AW          = $clog2(LB_DEPTH);
  localparam int DRAIN_CYCLES   = 24;
  localparam int TAIL_CYCLES    = 40;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int MAX_REPORTS    = 10;

  typedef struct {
    logic [MAG_W-1:0]         magnitude;
    logic signed [GRAD_W-1:0] grad_x;
    logic signed [GRAD_W-1:0] grad_y;
    logic                     last;
  } sobel_result_t;

  logic                   clk;
  logic                   rst_n = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata = '0;
  logic                   in_tuser = 1'b0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   out_tlast;
  logic                   cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_index = REG_IMAGE_WIDTH;
  logic [CFG_DATA_W-1:0]  cfg_wr_data = '0;

  // predictor state
  logic [PIX_W-1:0]   row_above [LB_DEPTH];
  logic [PIX_W-1:0]   row_two_above [LB_DEPTH];
  logic [PIX_W-1:0]   win [3][3] = '{default: '0};  // [row][column], column 2 newest
  int unsigned        col_pos = 0;
  int unsigned        row_pos = 0;
  logic [IMG_W_W-1:0] img_width = WIDTH_RESET;
  logic [IMG_H_W-1:0] img_height = HEIGHT_RESET;

  sobel_result_t pending_edges[$];
  int mismatches   = 0;
  int tx_idle_pct  = 0;
  int rx_stall_pct = 0;
  int sink_holdoff = 0;
  int quiet_cycles = 0;

  sobel_edge_magnitude_3x3_core uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_wr_data(cfg_wr_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic int unsigned active_width();
    if (img_width < 3) return 3;
    if (img_width > LB_DEPTH) return LB_DEPTH;
    return img_width;
  endfunction

  function automatic int unsigned active_height();
    return (img_height < 3) ? 3 : img_height;
  endfunction

  function automatic int unsigned floor_sqrt(input int unsigned v);
    int unsigned lo, hi, mid;
    lo = 0;
    hi = 2047;
    while (lo < hi) begin
      mid = (lo + hi + 1) / 2;
      if (mid * mid <= v) lo = mid;
      else hi = mid - 1;
    end
    return lo;
  endfunction

  function automatic logic [PIX_W-1:0] pick_pixel();
    case ($urandom_range(3))
      0: return '0;
      1: return '1;
      default: return PIX_W'($urandom_range(255));
    endcase
  endfunction

  function automatic void note_mismatch(input string msg);
    mismatches++;
    if (mismatches <= MAX_REPORTS) $display("mismatch at %0t: %s", $time, msg);
  endfunction

  // Advance the window by one accepted pixel and queue the gradient it completes.
  task automatic sobel_predict(input logic [PIX_W-1:0] pix, input logic frame_start);
    int unsigned w, h, c, r;
    logic [LB_AW-1:0] ci;
    logic [PIX_W-1:0] top, mid;
    int gx, gy;
    sobel_result_t res;
    w = active_width();
    h = active_height();
    if (frame_start) begin
      col_pos = 0;
      row_pos = 0;
    end
    if (col_pos >= w) begin
      col_pos = 0;
      row_pos++;
    end
    if (row_pos >= h) row_pos = 0;
    c = col_pos;
    r = row_pos;
    ci = c[LB_AW-1:0];
    top = row_two_above[ci];
    mid = row_above[ci];
    row_two_above[ci] = mid;
    row_above[ci] = pix;
    win[0][0] = win[0][1];
    win[0][1] = win[0][2];
    win[1][0] = win[1][1];
    win[1][1] = win[1][2];
    win[2][0] = win[2][1];
    win[2][1] = win[2][2];
    win[0][2] = top;
    win[1][2] = mid;
    win[2][2] = pix;
    if (r >= 2 && c >= 2) begin
      gx = (int'(win[0][2]) + 2 * int'(win[1][2]) + int'(win[2][2]))
         - (int'(win[0][0]) + 2 * int'(win[1][0]) + int'(win[2][0]));
      gy = (int'(win[2][0]) + 2 * int'(win[2][1]) + int'(win[2][2]))
         - (int'(win[0][0]) + 2 * int'(win[0][1]) + int'(win[0][2]));
      res.grad_x = gx[GRAD_W-1:0];
      res.grad_y = gy[GRAD_W-1:0];
      res.magnitude = MAG_W'(floor_sqrt(gx * gx + gy * gy));
      res.last = (r == h - 1) && (c == w - 1);
      pending_edges.push_back(res);
    end
    col_pos = c + 1;
    if (col_pos >= w) begin
      col_pos = 0;
      row_pos = r + 1;
      if (row_pos >= h) row_pos = 0;
    end
  endtask

  // Offer one pixel, idling first at the current rate; return after the transaction.
  task automatic push_pixel(input logic [PIX_W-1:0] pix, input logic frame_start);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= pix;
    in_tuser  <= frame_start;
    do @(posedge clk); while (in_tready !== 1'b1);
    sobel_predict(pix, frame_start);
  endtask

  // Drop valid, wait for every queued result, then let border pixels clear the pipe.
  task automatic settle();
    in_tvalid <= 1'b0;
    while (pending_edges.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_image_size(input logic [CFG_DATA_W-1:0] width_word,
                                input logic [CFG_DATA_W-1:0] height_word);
    settle();
    cfg_wr_en   <= 1'b1;
    cfg_index   <= REG_IMAGE_WIDTH;
    cfg_wr_data <= width_word;
    @(posedge clk);
    cfg_index   <= REG_IMAGE_HEIGHT;
    cfg_wr_data <= height_word;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    img_width  = width_word[IMG_W_W-1:0];
    img_height = height_word;
  endtask

  task automatic push_run(input int count, input logic start_frame);
    int i;
    for (i = 0; i < count; i++) push_pixel(pick_pixel(), start_frame && i == 0);
  endtask

  // Sizes left at their reset values: part of row zero, all border pixels.
  task automatic test_reset_sizes();
    push_run(24, 1'b1);
  endtask

  // 3x3 frames with step edges; later frames rely on the counter wrap.
  task automatic test_step_edges();
    logic [PIX_W-1:0] frames [3][9] = '{
      '{8'd0,   8'd0,   8'd255, 8'd0,   8'd0,   8'd255, 8'd0, 8'd0,   8'd255},
      '{8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd0, 8'd0,   8'd0},
      '{8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd255, 8'd0, 8'd255, 8'd255}
    };
    logic [1:0] f;
    logic [3:0] k;
    set_image_size(16'd3, 16'd3);
    for (f = 0; f < 3; f++)
      for (k = 0; k < 9; k++)
        push_pixel(frames[f][k], f == 0 && k == 0);
  endtask

  // Widest setting clamps to the buffer depth; row zero only.
  task automatic test_wide_rows();
    set_image_size(16'h0FFF, 16'hFFFF);
    push_run(24, 1'b1);
  endtask

  task automatic test_size_clamps();
    int unsigned widths [3]  = '{0, 2, 1};
    int unsigned heights [3] = '{2, 0, 1};
    logic [1:0] k;
    for (k = 0; k < 3; k++) begin
      set_image_size(CFG_DATA_W'(widths[k]), CFG_DATA_W'(heights[k]));
      push_run(18, 1'b1);
    end
  endtask

  task automatic test_frame_restart();
    set_image_size(16'd7, 16'd5);
    tx_idle_pct  = 17;
    rx_stall_pct = 17;
    push_run(17, 1'b1);
    // restart in the middle of row two, then run two frames on the wrap
    push_run(70, 1'b1);
  endtask

  task automatic test_resize_mid_frame();
    set_image_size(16'd10, 16'd8);
    push_run(35, 1'b1);
    set_image_size(16'd5, 16'd8);
    push_run(12, 1'b0);
    set_image_size(16'd5, 16'd3);
    push_run(30, 1'b0);
    set_image_size(16'd12, 16'd6);
    push_run(40, 1'b0);
  endtask

  task automatic test_backpressure();
    set_image_size(16'd8, 16'd10);
    tx_idle_pct  = 0;
    rx_stall_pct = 0;
    sink_holdoff = 400;
    push_run(80, 1'b1);
  endtask

  task automatic run_random_phase(input int tx_pct, input int rx_pct, input int items);
    int unsigned w, h, left;
    int n;
    logic fs;
    w = ($urandom_range(4) == 0) ? $urandom_range(2) : $urandom_range(16, 3);
    h = ($urandom_range(5) == 0) ? $urandom_range(2) : $urandom_range(10, 3);
    // upper nibble of the width word is junk the block must ignore
    set_image_size({4'($urandom_range(15)), 12'(w)}, 16'(h));
    tx_idle_pct  = tx_pct;
    rx_stall_pct = rx_pct;
    left = 0;
    for (n = 0; n < items; n++) begin
      fs = 1'b0;
      if (left == 0) begin
        fs = ($urandom_range(3) != 0);
        left = active_width() * active_height();
      end else if ($urandom_range(49) == 0) begin
        fs = 1'b1;
        left = active_width() * active_height();
      end
      push_pixel(pick_pixel(), fs);
      left--;
    end
  endtask

  task automatic test_random_phases();
    run_random_phase(0, 0, 35);
    run_random_phase(51, 0, 35);
    run_random_phase(0, 51, 35);
    run_random_phase(17, 17, 35);
  endtask

  // sink: long hold-off when requested, else random stalls
  always @(posedge clk) begin
    if (sink_holdoff > 0) begin
      out_tready <= 1'b0;
      sink_holdoff = sink_holdoff - 1;
    end else begin
      out_tready <= ($urandom_range(99) >= rx_stall_pct);
    end
  end

  always @(posedge clk) begin
    sobel_result_t want;
    if (rst_n === 1'b1 && out_tvalid === 1'b1 && out_tready === 1'b1) begin
      if (pending_edges.size() == 0) begin
        note_mismatch($sformatf("unexpected result tdata=%h tlast=%b", out_tdata, out_tlast));
      end else begin
        want = pending_edges.pop_front();
        if (out_tdata[MAG_W-1:0] !== want.magnitude ||
            out_tdata[MAG_W+GRAD_W-1:MAG_W] !== want.grad_x ||
            out_tdata[MAG_W+2*GRAD_W-1:MAG_W+GRAD_W] !== want.grad_y ||
            out_tdata[OUT_TDATA_W-1:MAG_W+2*GRAD_W] !== '0 ||
            out_tlast !== want.last)
          note_mismatch($sformatf(
            "expected mag %0d gx %0d gy %0d last %b, got mag %0d gx %0d gy %0d last %b pad %h",
            want.magnitude, want.grad_x, want.grad_y, want.last,
            out_tdata[MAG_W-1:0], $signed(out_tdata[MAG_W+GRAD_W-1:MAG_W]),
            $signed(out_tdata[MAG_W+2*GRAD_W-1:MAG_W+GRAD_W]), out_tlast,
            out_tdata[OUT_TDATA_W-1:MAG_W+2*GRAD_W]));
      end
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid === 1'b1 && in_tready === 1'b1) ||
        (out_tvalid === 1'b1 && out_tready === 1'b1)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles = quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("FAIL");
        $finish;
      end
    end
  end

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    test_reset_sizes();
    test_step_edges();
    test_wide_rows();
    test_size_clamps();
    test_frame_restart();
    test_resize_mid_frame();
    test_backpressure();
    test_random_phases();
    settle();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0 && pending_edges.size() == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

endmodule

FILE: filelist.f
+incdir+hdl
hdl/sem_pkg.sv
hdl/sem_line_buf.sv
hdl/sem_window.sv
hdl/sem_sqrt_cell.sv
hdl/sem_fifo.sv
hdl/sobel_edge_magnitude_3x3_core.sv
tb/tb.sv
